/* sv/c2p_pkg.sv */
// Shared constants, types and elaboration-time functions for the cartesian to polar core.
// Holds the CORDIC arctangent table and the gain compensation helper.
// No dependencies; used by sv/cartesian_to_polar_core.sv.
package c2p_pkg;

    localparam int DATA_WIDTH_DEFAULT   = 16;
    localparam int CORDIC_STEPS_DEFAULT = 16;

    // Fraction bits kept below the input scale during the iterations.
    localparam int GUARD_BITS = 16;

    // Angle accumulator width: pi is 2^31, and the sum may reach just past pi.
    localparam int ANGLE_ACC_WIDTH = 34;

    // Fraction width of the gain constant (unsigned Q32).
    localparam int GAIN_FRAC_BITS = 32;

    typedef struct packed {
        logic y_zero;
        logic x_neg;
    } axis_flags_t;

    // round(atan(2^-i) * 2^31 / pi)
    function automatic logic [31:0] atan_q31(input int idx);
        logic [31:0] val;
        case (idx)
            0:       val = 32'd536870912;
            1:       val = 32'd316933406;
            2:       val = 32'd167458907;
            3:       val = 32'd85004756;
            4:       val = 32'd42667331;
            5:       val = 32'd21354465;
            6:       val = 32'd10679838;
            7:       val = 32'd5340245;
            8:       val = 32'd2670163;
            9:       val = 32'd1335087;
            10:      val = 32'd667544;
            11:      val = 32'd333772;
            12:      val = 32'd166886;
            13:      val = 32'd83443;
            14:      val = 32'd41722;
            15:      val = 32'd20861;
            16:      val = 32'd10430;
            17:      val = 32'd5215;
            18:      val = 32'd2608;
            19:      val = 32'd1304;
            20:      val = 32'd652;
            21:      val = 32'd326;
            22:      val = 32'd163;
            23:      val = 32'd81;
            24:      val = 32'd41;
            25:      val = 32'd20;
            26:      val = 32'd10;
            27:      val = 32'd5;
            28:      val = 32'd3;
            29:      val = 32'd1;
            30:      val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

    // Integer square root of 2^60 * prod(1 + 2^-2i), each factor applied with a
    // truncating shift. The gain constant is 2^62 divided by this value.
    function automatic logic [63:0] gain_root(input int steps);
        logic [63:0] p;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        p = 64'd1 << 60;
        for (int i = 0; i < 32; i++) begin
            if (i < steps) begin
                p = p + (p >> (2 * i));
            end
        end
        v   = p;
        res = 64'd0;
        b   = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

endpackage

/* sv/cartesian_to_polar_core.sv */
// Pipelined CORDIC vectoring core: cartesian point in, magnitude and angle out.
// Depends on sv/c2p_pkg.sv for the arctangent table, gain helper and flag type.
//
// Usage:
//   Input stream s_axis_*: one point per transaction, x in the low half of
//   tdata and y above it, both signed DATA_WIDTH-bit values.
//   Output stream m_axis_*: one result per transaction, the unsigned
//   magnitude sqrt(x^2+y^2) in the low half and the signed angle atan2(y,x)
//   above it, where 2^(DATA_WIDTH-1) stands for pi (+pi reads as -pi).
//   From input to output transaction the pipeline has one quadrant
//   pre-rotation stage, one stage per CORDIC iteration, one stage of two
//   gain multipliers and one rounding/output stage. Every stage holds one point.
//   Throughput is one transaction per cycle unless the receiver stalls.
//   Each stage has its own valid bit and advances whenever it is empty or
//   the stage after it advances, so bubbles close up and the input keeps
//   accepting while a finished result waits at the output.
//   When the receiver stalls, results stay in place and nothing is dropped
//   or repeated; the input stalls only once every stage is occupied.
//   Reset clears all valid bits; data registers are not reset.
module cartesian_to_polar_core #(
    parameter int DATA_WIDTH   = c2p_pkg::DATA_WIDTH_DEFAULT,
    parameter int CORDIC_STEPS = c2p_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Fields from bit 0 up: x_coord, y_coord, zero padding to whole bytes.
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,

    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // Fields from bit 0 up: magnitude, angle, zero padding to whole bytes.
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]       m_axis_tdata
);

    localparam int TDW   = ((2*DATA_WIDTH+7)/8)*8;
    localparam int GB    = c2p_pkg::GUARD_BITS;
    localparam int XW    = DATA_WIDTH + GB + 3;
    localparam int ZW    = c2p_pkg::ANGLE_ACC_WIDTH;
    localparam int KW    = c2p_pkg::GAIN_FRAC_BITS;
    localparam int UW    = (XW - 1 > KW) ? XW - 1 : KW + 1;
    localparam int HW    = UW - KW;
    localparam int PW    = HW + KW + 1;
    localparam int MUL   = CORDIC_STEPS + 1;
    localparam int LAST  = CORDIC_STEPS + 2;
    localparam int ZSH   = 32 - DATA_WIDTH;

    localparam logic [63:0]        GAIN_ROOT = c2p_pkg::gain_root(CORDIC_STEPS);
    localparam logic [KW-1:0]      GAIN_K    = KW'((64'd1 << 62) / GAIN_ROOT);
    localparam logic signed [ZW-1:0] Z_ROUND = ZW'((64'd1 << ZSH) >> 1);
    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'd1 << 30);
    localparam logic [PW-1:0]      MAG_ROUND = PW'(64'd1 << (GB - 1));

    logic [LAST:0] valid_reg;
    logic [LAST:0] stage_ready;

    logic signed [XW-1:0]   x_reg [0:CORDIC_STEPS];
    logic signed [XW-1:0]   y_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0]   z_reg [0:MUL];
    c2p_pkg::axis_flags_t   flags_reg [0:MUL];

    // ---------------- Handshake and valid bits ----------------

    always_comb
    begin
        stage_ready[LAST] = !valid_reg[LAST] || m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign s_axis_tready = stage_ready[0];
    assign m_axis_tvalid = valid_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ---------------- Stage 0: quadrant pre-rotation ----------------

    logic signed [DATA_WIDTH-1:0] x_in;
    logic signed [DATA_WIDTH-1:0] y_in;
    logic signed [XW-1:0]         x_ext;
    logic signed [XW-1:0]         y_ext;
    logic signed [XW-1:0]         x0_next;
    logic signed [XW-1:0]         y0_next;
    logic signed [ZW-1:0]         z0_next;
    c2p_pkg::axis_flags_t         flags0_next;

    always_comb
    begin
        x_in  = s_axis_tdata[DATA_WIDTH-1:0];
        y_in  = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
        x_ext = {{3{x_in[DATA_WIDTH-1]}}, x_in, {GB{1'b0}}};
        y_ext = {{3{y_in[DATA_WIDTH-1]}}, y_in, {GB{1'b0}}};
        flags0_next.x_neg  = x_in[DATA_WIDTH-1];
        flags0_next.y_zero = (y_in == '0);
        // Points left of the y axis are turned by a quarter turn toward it.
        if (!x_in[DATA_WIDTH-1]) begin
            x0_next = x_ext;
            y0_next = y_ext;
            z0_next = '0;
        end else if (!y_in[DATA_WIDTH-1]) begin
            x0_next = y_ext;
            y0_next = -x_ext;
            z0_next = Z_QUARTER;
        end else begin
            x0_next = -y_ext;
            y0_next = x_ext;
            z0_next = -Z_QUARTER;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0]) begin
            x_reg[0]     <= x0_next;
            y_reg[0]     <= y0_next;
            z_reg[0]     <= z0_next;
            flags_reg[0] <= flags0_next;
        end
    end

    // ---------------- CORDIC vectoring stages ----------------

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        localparam logic signed [ZW-1:0] ATAN_I = ZW'(c2p_pkg::atan_q31(i));

        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (!y_reg[i][XW-1]) begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + ATAN_I;
            end else begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - ATAN_I;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[i+1]) begin
                x_reg[i+1]     <= x_next;
                y_reg[i+1]     <= y_next;
                z_reg[i+1]     <= z_next;
                flags_reg[i+1] <= flags_reg[i];
            end
        end
    end

    // ---------------- Gain multiply stage ----------------

    logic [UW-1:0]        x_mag;
    logic [63:0]          prod_lo_full;
    logic [KW-1:0]        prod_lo_next;
    logic [HW+KW-1:0]     prod_hi_next;
    logic [KW-1:0]        prod_lo_reg;
    logic [HW+KW-1:0]     prod_hi_reg;

    // The radius register is split at bit 32 so each product stays within 32x32.
    always_comb
    begin
        x_mag        = x_reg[CORDIC_STEPS][XW-1] ? '0 : UW'(x_reg[CORDIC_STEPS][XW-2:0]);
        prod_lo_full = 64'(x_mag[KW-1:0]) * 64'(GAIN_K);
        prod_lo_next = prod_lo_full[63:32];
        prod_hi_next = (HW+KW)'(x_mag[UW-1:KW]) * (HW+KW)'(GAIN_K);
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[MUL]) begin
            prod_lo_reg    <= prod_lo_next;
            prod_hi_reg    <= prod_hi_next;
            z_reg[MUL]     <= z_reg[CORDIC_STEPS];
            flags_reg[MUL] <= flags_reg[CORDIC_STEPS];
        end
    end

    // ---------------- Rounding and output stage ----------------

    logic [PW-1:0]                prod_sum;
    logic [PW-1:0]                mag_sum;
    logic signed [ZW-1:0]         z_sum;
    logic signed [ZW-1:0]         z_round;
    logic [DATA_WIDTH-1:0]        mag_next;
    logic [DATA_WIDTH-1:0]        angle_next;
    logic [DATA_WIDTH-1:0]        mag_reg;
    logic [DATA_WIDTH-1:0]        angle_reg;

    always_comb
    begin
        prod_sum = PW'(prod_hi_reg) + PW'(prod_lo_reg);
        mag_sum  = prod_sum + MAG_ROUND;
        mag_next = mag_sum[GB +: DATA_WIDTH];
        z_sum    = z_reg[MUL] + Z_ROUND;
        z_round  = z_sum >>> ZSH;
        // On the x axis the angle is exact: zero, or pi wrapped to -pi.
        if (flags_reg[MUL].y_zero) begin
            angle_next = flags_reg[MUL].x_neg ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : '0;
        end else begin
            angle_next = z_round[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[LAST]) begin
            mag_reg   <= mag_next;
            angle_reg <= angle_next;
        end
    end

    assign m_axis_tdata = TDW'({angle_reg, mag_reg});

endmodule
